// ===== rtl/scti_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the sine/cosine core.
// No dependencies; imported by every module of the block.
package scti_pkg;

   localparam int AngleFracBits = 8;
   localparam int AngleIntBits  = 16;
   localparam int AngleWidth    = AngleIntBits + AngleFracBits;
   localparam int OutFracBits   = 14;
   localparam int OutWidth      = 16;
   localparam int FullTurn      = 360;
   localparam int QuarterLen    = 91;

   // reciprocal of 360 in Q22, rounded up; exact floor quotient for the reduced range
   localparam int RecipShift = 22;
   localparam logic [13:0] Recip360 = 14'd11651;
   // offset that maps the biased whole degree back to floor modulo 360
   localparam logic [16:0] BiasFix = 17'd352;

   typedef logic [6:0] quarter_addr_type;
   typedef logic signed [OutWidth-1:0] sample_type;
   typedef sample_type quarter_table_type [QuarterLen];
   typedef int unsigned micro_table_type [QuarterLen];

   // reduced angle word between the reducer and the interpolator
   typedef struct packed {
      logic       valid;
      logic [8:0] index;
      logic [AngleFracBits-1:0] frac;
   } angle_type;

   // folded table address and sign of one lookup
   typedef struct packed {
      logic             neg;
      quarter_addr_type addr;
   } fold_type;

   // sine of 0..90 degrees in millionths
   localparam micro_table_type Micro = '{
      0, 17452, 34899, 52336, 69756, 87156, 104528, 121869, 139173, 156434,
      173648, 190809, 207912, 224951, 241922, 258819, 275637, 292372, 309017, 325568,
      342020, 358368, 374607, 390731, 406737, 422618, 438371, 453990, 469472, 484810,
      500000, 515038, 529919, 544639, 559193, 573576, 587785, 601815, 615662, 629320,
      642788, 656059, 669131, 681998, 694658, 707107, 719340, 731354, 743145, 754710,
      766044, 777146, 788011, 798635, 809017, 819152, 829038, 838671, 848048, 857167,
      866025, 874620, 882948, 891007, 898794, 906308, 913545, 920505, 927184, 933580,
      939693, 945519, 951057, 956305, 961262, 965926, 970296, 974370, 978148, 981627,
      984808, 987688, 990268, 992546, 994522, 996195, 997564, 998630, 999391, 999848,
      1000000
   };

   // round millionths to Q2.14 (evaluated at elaboration)
   function automatic quarter_table_type build_quarter();
      quarter_table_type t;
      longint unsigned   m;
      for (int i = 0; i < QuarterLen; i++) begin
         m = ((longint'(Micro[i]) << OutFracBits) + 64'd500000) / 64'd1000000;
         t[i] = sample_type'(m);
      end
      return t;
   endfunction

   localparam quarter_table_type QuarterSine = build_quarter();

   // fold a whole degree below 720 into a quarter-wave address and sign
   function automatic fold_type fold_degree(input logic [8:0] deg);
      fold_type   f;
      logic [8:0] d;
      d = (deg >= 9'd360) ? deg - 9'd360 : deg;
      f.neg = (d >= 9'd180);
      if (f.neg) begin
         d = d - 9'd180;
      end
      if (d > 9'd90) begin
         d = 9'd180 - d;
      end
      f.addr = d[6:0];
      return f;
   endfunction

endpackage

// ===== rtl/scti_reduce.sv =====
// Two-stage floor modulo 360 of the Q16.8 angle: reciprocal multiply, then remainder.
// Depends on scti_pkg.
module scti_reduce import scti_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [AngleWidth-1:0] angle,
   output angle_type             reduced
);

   logic [16:0] bias;
   logic [30:0] prod_in, prod_ff;
   logic [16:0] bias_ff;
   logic [AngleFracBits-1:0] frac_ff;
   logic        valid_ff;
   logic [8:0]  quot;
   logic [16:0] rem_full;
   angle_type   reduced_in, reduced_ff;

   // bias the signed whole degree so it is non-negative and still congruent mod 360
   assign bias    = {1'b0, ~angle[AngleWidth-1], angle[AngleWidth-2:AngleFracBits]} + BiasFix;
   assign prod_in = 31'(bias) * 31'(Recip360);

   // stage 1: reciprocal product
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start;
      end
      prod_ff <= prod_in;
      bias_ff <= bias;
      frac_ff <= angle[AngleFracBits-1:0];
   end

   // stage 2: remainder from quotient
   assign quot     = prod_ff[30:RecipShift];
   assign rem_full = bias_ff - 17'(quot * 17'd360);

   always_comb begin
      reduced_in.valid = valid_ff;
      reduced_in.index = rem_full[8:0];
      reduced_in.frac  = frac_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reduced_ff.valid <= 1'b0;
      end else begin
         reduced_ff.valid <= reduced_in.valid;
      end
      reduced_ff.index <= reduced_in.index;
      reduced_ff.frac  <= reduced_in.frac;
   end

   assign reduced = reduced_ff;

`ifndef NO_ASSERTIONS
   // remainder always lands on a base degree 0..359
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      reduced_ff.valid |-> (reduced_ff.index < 9'd360))
      else $error("reduced index out of range");
`endif

endmodule

// ===== rtl/scti_interp.sv =====
// Four-stage table lookup and linear interpolation of sine and cosine.
// Depends on scti_pkg; fed by scti_reduce.
module scti_interp import scti_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  angle_type  reduced,
   output logic       strobe,
   output sample_type sine_value,
   output sample_type cosine_value
);

   fold_type fs0_ff, fs1_ff, fc0_ff, fc1_ff;
   logic [AngleFracBits-1:0] frac3_ff, frac4_ff;
   logic valid3_ff, valid4_ff, valid5_ff, valid6_ff;
   sample_type s0_ff, s1_ff, c0_ff, c1_ff;
   sample_type sbase_ff, cbase_ff;
   logic signed [25:0] sprod_ff, cprod_ff;
   logic signed [16:0] sdiff, cdiff;
   logic signed [25:0] sround, cround;
   sample_type sine_in, cosine_in, sine_ff, cosine_ff;
   logic strobe_ff;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid3_ff <= reduced.valid;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
         strobe_ff <= valid5_ff;
      end
   end
   assign valid6_ff = strobe_ff;

   // stage 3: fold the four table addresses
   always_ff @(posedge clock) begin
      fs0_ff   <= fold_degree(reduced.index);
      fs1_ff   <= fold_degree(reduced.index + 9'd1);
      fc0_ff   <= fold_degree(reduced.index + 9'd90);
      fc1_ff   <= fold_degree(reduced.index + 9'd91);
      frac3_ff <= reduced.frac;
   end

   // stage 4: read the quarter-wave table and apply signs
   always_ff @(posedge clock) begin
      s0_ff <= fs0_ff.neg ? -QuarterSine[fs0_ff.addr] : QuarterSine[fs0_ff.addr];
      s1_ff <= fs1_ff.neg ? -QuarterSine[fs1_ff.addr] : QuarterSine[fs1_ff.addr];
      c0_ff <= fc0_ff.neg ? -QuarterSine[fc0_ff.addr] : QuarterSine[fc0_ff.addr];
      c1_ff <= fc1_ff.neg ? -QuarterSine[fc1_ff.addr] : QuarterSine[fc1_ff.addr];
      frac4_ff <= frac3_ff;
   end

   // stage 5: scale the slope by the fraction
   assign sdiff = 17'(s1_ff) - 17'(s0_ff);
   assign cdiff = 17'(c1_ff) - 17'(c0_ff);

   always_ff @(posedge clock) begin
      sprod_ff <= 26'(sdiff) * 26'($signed({1'b0, frac4_ff}));
      cprod_ff <= 26'(cdiff) * 26'($signed({1'b0, frac4_ff}));
      sbase_ff <= s0_ff;
      cbase_ff <= c0_ff;
   end

   // stage 6: round, floor shift and add to the base entry
   assign sround    = (sprod_ff + 26'sd128) >>> AngleFracBits;
   assign cround    = (cprod_ff + 26'sd128) >>> AngleFracBits;
   assign sine_in   = sbase_ff + sround[15:0];
   assign cosine_in = cbase_ff + cround[15:0];

   always_ff @(posedge clock) begin
      sine_ff   <= sine_in;
      cosine_ff <= cosine_in;
   end

   assign strobe       = valid6_ff;
   assign sine_value   = sine_ff;
   assign cosine_value = cosine_ff;

`ifndef NO_ASSERTIONS
   // interpolated values stay within one full unit
   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      strobe |-> (sine_value <= 16'sd16384 && sine_value >= -16'sd16384))
      else $error("sine out of range");
   a_cosine_range: assert property (@(posedge clock) disable iff (reset)
      strobe |-> (cosine_value <= 16'sd16384 && cosine_value >= -16'sd16384))
      else $error("cosine out of range");
`endif

endmodule

// ===== rtl/sine_cosine_table_interpolator_core.sv =====
// Channel   Ports                                   Handshake
// request   start, busy, req_angle_deg              accepted when start && !busy
// response  rsp_strobe, rsp_sine_value, rsp_cosine_value  one-cycle strobe, no stall
//
// One angle per clock; each result is presented with rsp_strobe after its start has passed
// through the pipeline: two reduce stages (reciprocal multiply, remainder),
// fold, table read, slope multiply and round/add.
// busy is always low; the receiver cannot stall, so nothing is held back.
// Synchronous reset clears the valid bits only.
module sine_cosine_table_interpolator_core import scti_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [AngleWidth-1:0] req_angle_deg,
   output logic                  rsp_strobe,
   output logic [OutWidth-1:0]   rsp_sine_value,
   output logic [OutWidth-1:0]   rsp_cosine_value
);

   angle_type  reduced;
   sample_type sine_w, cosine_w;

   assign busy = 1'b0;

   scti_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .angle   (req_angle_deg),
      .reduced (reduced)
   );

   scti_interp u_interp (
      .clock        (clock),
      .reset        (reset),
      .reduced      (reduced),
      .strobe       (rsp_strobe),
      .sine_value   (sine_w),
      .cosine_value (cosine_w)
   );

   assign rsp_sine_value   = sine_w;
   assign rsp_cosine_value = cosine_w;

`ifndef NO_ASSERTIONS
   // every accepted word comes back with rsp_strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_strobe)
      else $error("result missing after latency");
`endif

endmodule

// ===== verif/sine_cosine_table_interpolator_core_tb.sv =====
// Testbench for the sine/cosine table interpolator core: drives angle words and checks
// each sine/cosine word against a local table-and-interpolate predictor.
// Depends on scti_pkg and sine_cosine_table_interpolator_core.
`timescale 1ns / 100ps

module sine_cosine_table_interpolator_core_tb;
   import scti_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 20;

   typedef struct {
      logic [OutWidth-1:0] sine;
      logic [OutWidth-1:0] cosine;
   } trig_word_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [AngleWidth-1:0] req_angle_deg;
   logic                  rsp_strobe;
   logic [OutWidth-1:0]   rsp_sine_value;
   logic [OutWidth-1:0]   rsp_cosine_value;

   logic [AngleWidth-1:0] pending_angles[$];
   trig_word_type         expected_trig[$];
   longint                micro_degree[361];
   int                    mismatch_count;
   int                    idle_cycles;
   int                    gap_left;
   int                    next_gap;
   bit                    stimulus_done;

   sine_cosine_table_interpolator_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_angle_deg    (req_angle_deg),
      .rsp_strobe       (rsp_strobe),
      .rsp_sine_value   (rsp_sine_value),
      .rsp_cosine_value (rsp_cosine_value)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // sine of a whole degree in Q2.14, rounded half away from zero
   function automatic longint sine_of_degree(int deg);
      int     d;
      bit     neg;
      longint mag;
      d   = deg % FullTurn;
      neg = d >= 180;
      if (neg) begin
         d = d - 180;
      end
      if (d > 90) begin
         d = 180 - d;
      end
      mag = ((longint'(micro_degree[d]) << OutFracBits) + 500000) / 1000000;
      return neg ? -mag : mag;
   endfunction

   function automatic longint blend(longint lo, longint hi, longint frac);
      return lo + ((frac * (hi - lo) + (1 << (AngleFracBits - 1))) >>> AngleFracBits);
   endfunction

   // reduce modulo a full turn, then interpolate sine and cosine from the table
   function automatic trig_word_type predict_trig(logic [AngleWidth-1:0] angle);
      longint        a;
      longint        r;
      int            idx;
      longint        frac;
      trig_word_type w;
      a = longint'($signed(angle));
      r = a % (FullTurn << AngleFracBits);
      if (r < 0) begin
         r = r + (FullTurn << AngleFracBits);
      end
      idx  = int'(r >> AngleFracBits);
      frac = r & ((1 << AngleFracBits) - 1);
      w.sine   = OutWidth'(blend(sine_of_degree(idx), sine_of_degree(idx + 1), frac));
      w.cosine = OutWidth'(blend(sine_of_degree(idx + 90), sine_of_degree(idx + 91), frac));
      return w;
   endfunction

   task automatic report_mismatch(string what, logic [OutWidth-1:0] got,
                                  logic [OutWidth-1:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // driver: present the next word after a random gap
   always @(negedge clock) begin
      if (reset) begin
         start         <= 1'b0;
         req_angle_deg <= '0;
         gap_left      <= $urandom_range(0, 15);
      end else if (start && !busy) begin
         next_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         if (next_gap == 0 && pending_angles.size() > 0) begin
            start         <= 1'b1;
            req_angle_deg <= pending_angles.pop_front();
         end else begin
            start    <= 1'b0;
            gap_left <= next_gap;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_angles.size() > 0) begin
            start         <= 1'b1;
            req_angle_deg <= pending_angles.pop_front();
         end
      end
   end

   // monitor: log accepted words, check results, watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (start && !busy) begin
            expected_trig.push_back(predict_trig(req_angle_deg));
         end
         if (rsp_strobe) begin
            if (expected_trig.size() == 0) begin
               report_mismatch("unexpected word", rsp_sine_value, '0);
            end else begin
               trig_word_type w;
               w = expected_trig.pop_front();
               if (rsp_sine_value !== w.sine) begin
                  report_mismatch("sine", rsp_sine_value, w.sine);
               end
               if (rsp_cosine_value !== w.cosine) begin
                  report_mismatch("cosine", rsp_cosine_value, w.cosine);
               end
            end
         end
         if ((start && !busy) || rsp_strobe || stimulus_done) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      int deg;
      int wait_count;
      micro_degree = '{default: 0};
      for (int i = 0; i < QuarterLen; i++) begin
         micro_degree[i] = Micro[i];
      end
      mismatch_count = 0;
      stimulus_done  = 1'b0;
      reset          = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, zero, negatives, top of table, quadrant edges
      pending_angles.push_back(24'h000000);
      pending_angles.push_back(24'h7FFFFF);
      pending_angles.push_back(24'h800000);
      pending_angles.push_back(24'hFFFFFF);
      pending_angles.push_back(24'(-128));
      pending_angles.push_back(24'(359 * 256 + 128));
      pending_angles.push_back(24'(359 * 256 + 255));
      pending_angles.push_back(24'(360 * 256));
      pending_angles.push_back(24'(-360 * 256));
      pending_angles.push_back(24'(-360 * 256 - 1));
      pending_angles.push_back(24'(90 * 256));
      pending_angles.push_back(24'(180 * 256));
      pending_angles.push_back(24'(270 * 256));
      pending_angles.push_back(24'(89 * 256 + 255));
      pending_angles.push_back(24'(-90 * 256));
      pending_angles.push_back(24'(720 * 256 + 1));
      pending_angles.push_back(24'h555555);
      pending_angles.push_back(24'hAAAAAA);

      // random: mostly full range, some near a single turn
      for (int n = 0; n < 450; n++) begin
         if ($urandom_range(0, 2) == 0) begin
            deg = $urandom_range(0, 720 * 256 - 1) - 360 * 256;
            pending_angles.push_back(24'(deg));
         end else begin
            pending_angles.push_back(24'($urandom));
         end
      end

      wait (pending_angles.size() == 0);
      @(posedge clock);
      wait (!start);
      stimulus_done = 1'b1;
      wait_count = 0;
      while (expected_trig.size() > 0 && wait_count < WatchdogLimit) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_trig.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
